>>> hdl/tte_pkg.sv
package tte_pkg;

    localparam int TAP_HISTORY_DEF = 4;

    localparam int TIME_W    = 40;
    localparam int GAP_W     = 24;
    localparam int TEMPO_W   = 20;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Numerator 60e9 * (count - 1) stays below 2^41 for up to 32 held taps.
    localparam int NUM_W = 41;
    localparam logic [NUM_W-1:0] MILLI_MINUTE_US = 41'd60000000000;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO   = 2'd2;

    localparam logic [GAP_W-1:0]   GAP_TIMEOUT_RST = 24'd2000000;
    localparam logic [TEMPO_W-1:0] MIN_TEMPO_RST   = 20'd30000;
    localparam logic [TEMPO_W-1:0] MAX_TEMPO_RST   = 20'd240000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_RD_OLD,
        ST_SPAN,
        ST_DIV,
        ST_ROUND,
        ST_DONE
    } tte_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hdl/tap_tempo_estimator_unit.sv
// A computed tempo takes an accepted tap through the gap check, the oldest-tap read, the
// span, 41 restoring divider steps, rounding and the output load. No new tap is taken
// until the result beat is loaded, so the iterative divider holds taps back on that path;
// a result beat waiting at the output holds the next one back. Fewer than three held taps
// go from the gap check straight to the output load; a non-positive span skips the divider.
// Reset (rst_n, asynchronous, active low) empties the tap history and restores defaults.
module tap_tempo_estimator_unit #(
    parameter int TAP_HISTORY = tte_pkg::TAP_HISTORY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,   // [39:0] tap_time_us
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [19:0] tempo_milli, [23:20] zero
    output logic                          m_tuser,   // [0] tempo_valid
    input  logic                          cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tte_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int IDX_W   = $clog2(TAP_HISTORY);
    localparam int CNT_W   = $clog2(TAP_HISTORY + 1);
    localparam int TIME_W  = tte_pkg::TIME_W;
    localparam int TEMPO_W = tte_pkg::TEMPO_W;
    localparam int GAP_W   = tte_pkg::GAP_W;
    localparam int NUM_W   = tte_pkg::NUM_W;

    tte_pkg::tte_state_t state_reg, state_next;

    logic [GAP_W-1:0]   gap_timeout_reg;
    logic [TEMPO_W-1:0] min_tempo_reg;
    logic [TEMPO_W-1:0] max_tempo_reg;

    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [TIME_W-1:0]  now_reg;
    logic               res_ok_reg, res_ok_next;
    logic [NUM_W:0]     q_rnd_reg;
    logic [TIME_W-1:0]  den_hold_reg;

    logic               m_tvalid_reg;
    logic [TEMPO_W-1:0] tempo_reg;
    logic               tempo_valid_reg;

    // RAM and divider hookup
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [TIME_W-1:0]  ram_rdata;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [NUM_W-1:0]   div_q;
    logic [TIME_W-1:0]  div_r;
    tte_pkg::div_stat_t div_stat;

    logic               in_beat;
    logic               out_free;
    logic [IDX_W-1:0]   last_slot;
    logic [TIME_W:0]    t_diff;
    logic               restart;
    logic [IDX_W-1:0]   slot_eff;
    logic [CNT_W-1:0]   held_base;
    logic [CNT_W-1:0]   held_new;
    logic [IDX_W-1:0]   slot_after;
    logic [IDX_W:0]     oldest_sum;
    logic [IDX_W-1:0]   oldest_calc;
    logic               span_ok;
    logic [TIME_W:0]    twice_r;
    logic               round_up;
    logic [TEMPO_W-1:0] clamped;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign last_slot = (slot_reg == '0) ? IDX_W'(TAP_HISTORY - 1) : slot_reg - IDX_W'(1);

    // Signed 41-bit difference of the current tap against the word read back,
    // shared by the gap check and the span.
    assign t_diff = {1'b0, now_reg} - {1'b0, ram_rdata};

    assign restart = (held_reg != '0) && !t_diff[TIME_W]
                     && (t_diff[TIME_W-1:0] > TIME_W'(gap_timeout_reg));
    assign slot_eff   = restart ? '0 : slot_reg;
    assign held_base  = restart ? '0 : held_reg;
    assign held_new   = (held_base == CNT_W'(TAP_HISTORY)) ? held_base
                                                           : held_base + CNT_W'(1);
    assign slot_after = (slot_eff == IDX_W'(TAP_HISTORY - 1)) ? '0 : slot_eff + IDX_W'(1);

    assign oldest_sum  = (IDX_W+1)'(slot_after) + (IDX_W+1)'(TAP_HISTORY)
                         - (IDX_W+1)'(held_new);
    assign oldest_calc = (oldest_sum >= (IDX_W+1)'(TAP_HISTORY))
                         ? IDX_W'(oldest_sum - (IDX_W+1)'(TAP_HISTORY))
                         : IDX_W'(oldest_sum);

    assign span_ok = !t_diff[TIME_W] && (t_diff[TIME_W-1:0] != '0);

    assign div_num = NUM_W'(tte_pkg::MILLI_MINUTE_US * NUM_W'(held_reg - CNT_W'(1)));

    // Round half to even: compare twice the remainder with the divisor.
    assign twice_r  = {div_r, 1'b0};
    assign round_up = (twice_r > {1'b0, den_hold_reg}) ||
                      ((twice_r == {1'b0, den_hold_reg}) && div_q[0]);

    always_comb
    begin
        if (q_rnd_reg < (NUM_W+1)'(min_tempo_reg))
        begin
            clamped = min_tempo_reg;
        end
        else if (q_rnd_reg > (NUM_W+1)'(max_tempo_reg))
        begin
            clamped = max_tempo_reg;
        end
        else
        begin
            clamped = q_rnd_reg[TEMPO_W-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tte_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = tte_pkg::ST_GAP;
                end
            end
            tte_pkg::ST_GAP:
            begin
                state_next = (held_new < CNT_W'(3)) ? tte_pkg::ST_DONE : tte_pkg::ST_RD_OLD;
            end
            tte_pkg::ST_RD_OLD:
            begin
                state_next = tte_pkg::ST_SPAN;
            end
            tte_pkg::ST_SPAN:
            begin
                state_next = span_ok ? tte_pkg::ST_DIV : tte_pkg::ST_DONE;
            end
            tte_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = tte_pkg::ST_ROUND;
                end
            end
            tte_pkg::ST_ROUND:
            begin
                state_next = tte_pkg::ST_DONE;
            end
            tte_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tte_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tte_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = slot_eff;
        ram_raddr   = last_slot;
        div_start   = 1'b0;
        slot_next   = slot_reg;
        held_next   = held_reg;
        oldest_next = oldest_reg;
        res_ok_next = res_ok_reg;
        unique case (state_reg)
            tte_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                res_ok_next = 1'b0;
            end
            tte_pkg::ST_GAP:
            begin
                ram_we      = 1'b1;
                slot_next   = slot_after;
                held_next   = held_new;
                oldest_next = oldest_calc;
            end
            tte_pkg::ST_RD_OLD:
            begin
                ram_raddr = oldest_reg;
            end
            tte_pkg::ST_SPAN:
            begin
                div_start = span_ok && !div_stat.busy;
            end
            tte_pkg::ST_ROUND:
            begin
                res_ok_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tte_pkg::ST_IDLE;
            slot_reg        <= '0;
            held_reg        <= '0;
            res_ok_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            gap_timeout_reg <= tte_pkg::GAP_TIMEOUT_RST;
            min_tempo_reg   <= tte_pkg::MIN_TEMPO_RST;
            max_tempo_reg   <= tte_pkg::MAX_TEMPO_RST;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            held_reg   <= held_next;
            res_ok_reg <= res_ok_next;
            if ((state_reg == tte_pkg::ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tte_pkg::CFG_GAP_TIMEOUT: gap_timeout_reg <= cfg_wdata[GAP_W-1:0];
                    tte_pkg::CFG_MIN_TEMPO:   min_tempo_reg   <= cfg_wdata[TEMPO_W-1:0];
                    tte_pkg::CFG_MAX_TEMPO:   max_tempo_reg   <= cfg_wdata[TEMPO_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oldest_reg <= oldest_next;
        if (in_beat)
        begin
            now_reg <= s_tdata[TIME_W-1:0];
        end
        if (state_reg == tte_pkg::ST_SPAN)
        begin
            den_hold_reg <= t_diff[TIME_W-1:0];
        end
        if (state_reg == tte_pkg::ST_ROUND)
        begin
            q_rnd_reg <= (NUM_W+1)'(div_q) + (NUM_W+1)'(round_up);
        end
        if ((state_reg == tte_pkg::ST_DONE) && out_free)
        begin
            tempo_valid_reg <= res_ok_reg;
            tempo_reg       <= res_ok_reg ? clamped : '0;
        end
    end

    tte_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TAP_HISTORY)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (now_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tte_divider #(
        .NUM_W (NUM_W),
        .DEN_W (TIME_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .num       (div_num),
        .den       (t_diff[TIME_W-1:0]),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, tempo_reg};
    assign m_tuser  = tempo_valid_reg;

endmodule

>>> hdl/tte_ram.sv
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tte_divider.sv
module tte_divider #(
    parameter int NUM_W = tte_pkg::NUM_W,
    parameter int DEN_W = tte_pkg::TIME_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output logic [NUM_W-1:0]    quotient,
    output logic [DEN_W-1:0]    remainder,
    output tte_pkg::div_stat_t  stat
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // One restoring step per cycle; the dividend shifts out of the top of the
    // quotient register while quotient bits shift in at the bottom.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hdl/tte_checker.sv
module tte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // A result beat held back by the sink keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // A beat without an estimate carries a zero tempo.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 24'd0)
        else $error("invalid result with nonzero tempo");

    // After taking a tap the unit is busy and does not take another tap straight away.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("tap accepted while still working");

    // A new result only appears while no tap can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a finished tap");

endmodule

bind tap_tempo_estimator_unit tte_checker u_tte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
